@@ hdl/ppe_pkg.sv @@
// Shared types and constants for the particle pool engine.
// Depends on nothing; the interfaces, the top module and the testbench use it.
package ppe_pkg;

  typedef enum logic [1:0] {
    KIND_EMIT = 2'd0,
    KIND_TICK = 2'd1,
    KIND_DRAW = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_VEL_JIT_X  = 3'd0,
    REG_VEL_JIT_Y  = 3'd1,
    REG_START_COL  = 3'd2,
    REG_FINAL_COL  = 3'd3,
    REG_START_SIZE = 3'd4,
    REG_FINAL_SIZE = 3'd5,
    REG_SIZE_JIT   = 3'd6,
    REG_LIFESPAN   = 3'd7
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EM_ROT,
    ST_EM_JX,
    ST_EM_JY,
    ST_EM_JS,
    ST_EM_WR,
    ST_TK_SPIN,
    ST_TK_SPINCAP,
    ST_TK_RD,
    ST_TK_CHK,
    ST_TK_MY,
    ST_TK_WB,
    ST_RN_RD,
    ST_RN_CHK,
    ST_RN_DIV,
    ST_RN_MS,
    ST_RN_MR,
    ST_RN_MG,
    ST_RN_MB,
    ST_RN_MA,
    ST_RN_AL,
    ST_RN_AF,
    ST_RN_OUT
  } state_e;

  localparam int unsigned PADDR_W = 5;
  localparam logic [31:0] RNG_SEED = 32'h2545F491;
  localparam logic [22:0] SPIN_K = 23'd6835653;
  localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
  localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] spawn_x;
    logic signed [31:0] spawn_y;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic [15:0]        step_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] draw_x;
    logic signed [31:0] draw_y;
    logic [15:0]        draw_size;
    logic [15:0]        draw_angle;
    logic [31:0]        draw_color;
    logic               slot_live;
    logic               last_slot;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [15:0]        angle;
    logic [31:0]        col_a;
    logic [31:0]        col_b;
    logic [15:0]        size_a;
    logic [15:0]        size_b;
    logic [23:0]        life_tot;
    logic signed [24:0] life_left;
  } slot_t;

  function automatic logic [31:0] xorshift(input logic [31:0] s);
    logic [31:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/ppe_in_if.sv @@
// Input item channel: valid/ready handshake with the item payload.
// Depends on ppe_pkg.
interface ppe_in_if;
  logic               valid;
  logic               ready;
  ppe_pkg::in_item_t  item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

@@ hdl/ppe_out_if.sv @@
// Result item channel: valid/ready handshake with the draw payload.
// Depends on ppe_pkg.
interface ppe_out_if;
  logic               valid;
  logic               ready;
  ppe_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

@@ hdl/particle_pool_engine_top.sv @@
// Particle pool engine: sequencer, slot RAM, shared multiplier and divider.
// Each item is taken in the idle state, then: emit fills one slot; tick walks every slot,
// clearing the live flag of free or expiring slots and ageing live ones; render sends one
// result per slot, using the divider only for live slots with partial life, and waits on output stalls.
// Reset clears all live flags at once, sets the ring index to the top slot and
// seeds the generator; slot contents are left as they are.
module particle_pool_engine_top #(
  parameter int unsigned POOL_SIZE = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ppe_in_if.sink                       in_i,
  ppe_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppe_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned IDX_W = $clog2(POOL_SIZE);
  localparam int unsigned REC_W = $bits(ppe_pkg::slot_t);

  // configuration
  logic [30:0] vjx_q, vjy_q;
  logic [31:0] scol_q, fcol_q;
  logic [15:0] ssize_q, fsize_q, sjit_q;
  logic [23:0] life_q;
  logic        cfg_wr;

  ppe_pkg::state_e    state_q, state_d;
  ppe_pkg::in_item_t  in_q, in_d;
  ppe_pkg::slot_t     rec_q, rec_d;
  ppe_pkg::out_item_t out_item_q, out_item_d;
  logic               out_vld_q, out_vld_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   ring_q, ring_d;
  logic [31:0]        rng_q, rng_d;
  logic [POOL_SIZE-1:0] live_q, live_d;
  logic signed [31:0] velx_q, velx_d, vely_q, vely_d;
  logic [15:0]        angle_q, angle_d;
  logic [15:0]        spin_q, spin_d;
  logic [16:0]        lr_q, lr_d;
  logic [15:0]        sz_q, sz_d;
  logic [31:0]        col_q, col_d;

  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] prod;
  logic signed [50:0] prod_sh;
  logic signed [50:0] spin_sum;
  logic [31:0]        rng_nxt;
  logic signed [17:0] jit_b;
  logic signed [17:0] lr_b;
  logic signed [17:0] size_sum;
  logic [7:0]         mix_a;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  ppe_pkg::slot_t     ram_wdata;
  logic [REC_W-1:0]   ram_rdata_raw;
  ppe_pkg::slot_t     ram_rdata;

  logic               div_start;
  logic               div_done;
  logic [15:0]        div_quo;

  logic               last;
  logic               out_free;

  function automatic logic signed [32:0] diff8(input logic [7:0] a, input logic [7:0] b);
    return $signed({25'b0, a}) - $signed({25'b0, b});
  endfunction

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (ppe_pkg::cfg_reg_e'(paddr[4:2]))
      ppe_pkg::REG_VEL_JIT_X:  prdata = {1'b0, vjx_q};
      ppe_pkg::REG_VEL_JIT_Y:  prdata = {1'b0, vjy_q};
      ppe_pkg::REG_START_COL:  prdata = scol_q;
      ppe_pkg::REG_FINAL_COL:  prdata = fcol_q;
      ppe_pkg::REG_START_SIZE: prdata = {16'b0, ssize_q};
      ppe_pkg::REG_FINAL_SIZE: prdata = {16'b0, fsize_q};
      ppe_pkg::REG_SIZE_JIT:   prdata = {16'b0, sjit_q};
      ppe_pkg::REG_LIFESPAN:   prdata = {8'b0, life_q};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vjx_q   <= '0;
      vjy_q   <= '0;
      scol_q  <= 32'hFFFFFFFF;
      fcol_q  <= '0;
      ssize_q <= 16'd256;
      fsize_q <= '0;
      sjit_q  <= '0;
      life_q  <= 24'd65536;
    end else if (cfg_wr) begin
      case (ppe_pkg::cfg_reg_e'(paddr[4:2]))
        ppe_pkg::REG_VEL_JIT_X:  vjx_q   <= pwdata[30:0];
        ppe_pkg::REG_VEL_JIT_Y:  vjy_q   <= pwdata[30:0];
        ppe_pkg::REG_START_COL:  scol_q  <= pwdata;
        ppe_pkg::REG_FINAL_COL:  fcol_q  <= pwdata;
        ppe_pkg::REG_START_SIZE: ssize_q <= pwdata[15:0];
        ppe_pkg::REG_FINAL_SIZE: fsize_q <= pwdata[15:0];
        ppe_pkg::REG_SIZE_JIT:   sjit_q  <= pwdata[15:0];
        ppe_pkg::REG_LIFESPAN:   life_q  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // shared units
  ppe_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  ppe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (ram_rdata.life_left[23:0]),
    .den_i   (ram_rdata.life_tot),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  ppe_ram #(
    .WIDTH (REC_W),
    .DEPTH (POOL_SIZE)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = ppe_pkg::slot_t'(ram_rdata_raw);

  assign rng_nxt  = ppe_pkg::xorshift(rng_q);
  assign jit_b    = $signed({2'b0, rng_nxt[31:16]}) - 18'sd32768;
  assign lr_b     = $signed({1'b0, lr_q});
  assign prod_sh  = prod >>> 16;
  assign spin_sum = prod + 51'sd2147483648;
  assign size_sum = $signed({2'b0, ssize_q}) + prod_sh[17:0];
  assign mix_a    = prod_sh[7:0] + rec_q.col_b[7:0];
  assign last     = (cnt_q == IDX_W'(POOL_SIZE - 1));
  assign out_free = !out_vld_q || out_o.ready;

  assign in_i.ready  = (state_q == ppe_pkg::ST_IDLE);
  assign out_o.valid = out_vld_q;
  assign out_o.item  = out_item_q;

  always_comb begin
    state_d    = state_q;
    in_d       = in_q;
    rec_d      = rec_q;
    out_item_d = out_item_q;
    out_vld_d  = out_vld_q;
    cnt_d      = cnt_q;
    ring_d     = ring_q;
    rng_d      = rng_q;
    live_d     = live_q;
    velx_d     = velx_q;
    vely_d     = vely_q;
    angle_d    = angle_q;
    spin_d     = spin_q;
    lr_d       = lr_q;
    sz_d       = sz_q;
    col_d      = col_q;
    mul_a      = '0;
    mul_b      = '0;
    ram_we     = 1'b0;
    ram_waddr  = cnt_q;
    ram_wdata  = rec_q;
    div_start  = 1'b0;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ppe_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          in_d  = in_i.item;
          cnt_d = '0;
          case (in_i.item.kind)
            ppe_pkg::KIND_EMIT: state_d = ppe_pkg::ST_EM_ROT;
            ppe_pkg::KIND_TICK: state_d = ppe_pkg::ST_TK_SPIN;
            ppe_pkg::KIND_DRAW: state_d = ppe_pkg::ST_RN_RD;
            default:            state_d = ppe_pkg::ST_IDLE;
          endcase
        end
      end

      // emit: rotation, then x, y and size jitter through the multiplier
      ppe_pkg::ST_EM_ROT: begin
        rng_d   = rng_nxt;
        angle_d = rng_nxt[31:16];
        state_d = ppe_pkg::ST_EM_JX;
      end
      ppe_pkg::ST_EM_JX: begin
        rng_d   = rng_nxt;
        mul_a   = $signed({2'b0, vjx_q});
        mul_b   = jit_b;
        state_d = ppe_pkg::ST_EM_JY;
      end
      ppe_pkg::ST_EM_JY: begin
        rng_d   = rng_nxt;
        mul_a   = $signed({2'b0, vjy_q});
        mul_b   = jit_b;
        velx_d  = ppe_pkg::sat32(34'(in_q.speed_x) + prod_sh[33:0]);
        state_d = ppe_pkg::ST_EM_JS;
      end
      ppe_pkg::ST_EM_JS: begin
        rng_d   = rng_nxt;
        mul_a   = $signed({17'b0, sjit_q});
        mul_b   = jit_b;
        vely_d  = ppe_pkg::sat32(34'(in_q.speed_y) + prod_sh[33:0]);
        state_d = ppe_pkg::ST_EM_WR;
      end
      ppe_pkg::ST_EM_WR: begin
        ram_we              = 1'b1;
        ram_waddr           = ring_q;
        ram_wdata.pos_x     = in_q.spawn_x;
        ram_wdata.pos_y     = in_q.spawn_y;
        ram_wdata.vel_x     = velx_q;
        ram_wdata.vel_y     = vely_q;
        ram_wdata.angle     = angle_q;
        ram_wdata.col_a     = scol_q;
        ram_wdata.col_b     = fcol_q;
        if (size_sum < 0) begin
          ram_wdata.size_a = '0;
        end else if (size_sum > 18'sd65535) begin
          ram_wdata.size_a = 16'hFFFF;
        end else begin
          ram_wdata.size_a = size_sum[15:0];
        end
        ram_wdata.size_b    = fsize_q;
        ram_wdata.life_tot  = life_q;
        ram_wdata.life_left = $signed({1'b0, life_q});
        live_d[ring_q]      = 1'b1;
        ring_d  = (ring_q == '0) ? IDX_W'(POOL_SIZE - 1) : ring_q - 1'b1;
        state_d = ppe_pkg::ST_IDLE;
      end

      // tick: spin once, then walk the slots
      ppe_pkg::ST_TK_SPIN: begin
        mul_a   = $signed({10'b0, ppe_pkg::SPIN_K});
        mul_b   = $signed({2'b0, in_q.step_time});
        state_d = ppe_pkg::ST_TK_SPINCAP;
      end
      ppe_pkg::ST_TK_SPINCAP: begin
        spin_d  = spin_sum[47:32];
        state_d = ppe_pkg::ST_TK_RD;
      end
      ppe_pkg::ST_TK_RD: begin
        state_d = ppe_pkg::ST_TK_CHK;
      end
      ppe_pkg::ST_TK_CHK: begin
        rec_d = ram_rdata;
        if (!live_q[cnt_q] || ram_rdata.life_left <= 0) begin
          live_d[cnt_q] = 1'b0;
          cnt_d   = cnt_q + 1'b1;
          state_d = last ? ppe_pkg::ST_IDLE : ppe_pkg::ST_TK_RD;
        end else begin
          mul_a   = 33'(ram_rdata.vel_x);
          mul_b   = $signed({2'b0, in_q.step_time});
          state_d = ppe_pkg::ST_TK_MY;
        end
      end
      ppe_pkg::ST_TK_MY: begin
        mul_a       = 33'(rec_q.vel_y);
        mul_b       = $signed({2'b0, in_q.step_time});
        rec_d.pos_x = ppe_pkg::sat32(34'(rec_q.pos_x) + prod_sh[33:0]);
        state_d     = ppe_pkg::ST_TK_WB;
      end
      ppe_pkg::ST_TK_WB: begin
        ram_we              = 1'b1;
        ram_wdata.pos_y     = ppe_pkg::sat32(34'(rec_q.pos_y) + prod_sh[33:0]);
        ram_wdata.angle     = rec_q.angle + spin_q;
        ram_wdata.life_left = rec_q.life_left - $signed({9'b0, in_q.step_time});
        cnt_d   = cnt_q + 1'b1;
        state_d = last ? ppe_pkg::ST_IDLE : ppe_pkg::ST_TK_RD;
      end

      // render: life ratio, then five mixes and the alpha fade
      ppe_pkg::ST_RN_RD: begin
        state_d = ppe_pkg::ST_RN_CHK;
      end
      ppe_pkg::ST_RN_CHK: begin
        rec_d = ram_rdata;
        if (!live_q[cnt_q]) begin
          state_d = ppe_pkg::ST_RN_OUT;
        end else if (ram_rdata.life_left <= 0 || ram_rdata.life_tot == '0) begin
          lr_d    = '0;
          state_d = ppe_pkg::ST_RN_MS;
        end else if (ram_rdata.life_left[23:0] >= ram_rdata.life_tot) begin
          lr_d    = 17'd65536;
          state_d = ppe_pkg::ST_RN_MS;
        end else begin
          div_start = 1'b1;
          state_d   = ppe_pkg::ST_RN_DIV;
        end
      end
      ppe_pkg::ST_RN_DIV: begin
        if (div_done) begin
          lr_d    = {1'b0, div_quo};
          state_d = ppe_pkg::ST_RN_MS;
        end
      end
      ppe_pkg::ST_RN_MS: begin
        mul_a   = $signed({17'b0, rec_q.size_a}) - $signed({17'b0, rec_q.size_b});
        mul_b   = lr_b;
        state_d = ppe_pkg::ST_RN_MR;
      end
      ppe_pkg::ST_RN_MR: begin
        mul_a   = diff8(rec_q.col_a[31:24], rec_q.col_b[31:24]);
        mul_b   = lr_b;
        sz_d    = prod_sh[15:0] + rec_q.size_b;
        state_d = ppe_pkg::ST_RN_MG;
      end
      ppe_pkg::ST_RN_MG: begin
        mul_a          = diff8(rec_q.col_a[23:16], rec_q.col_b[23:16]);
        mul_b          = lr_b;
        col_d[31:24]   = prod_sh[7:0] + rec_q.col_b[31:24];
        state_d        = ppe_pkg::ST_RN_MB;
      end
      ppe_pkg::ST_RN_MB: begin
        mul_a          = diff8(rec_q.col_a[15:8], rec_q.col_b[15:8]);
        mul_b          = lr_b;
        col_d[23:16]   = prod_sh[7:0] + rec_q.col_b[23:16];
        state_d        = ppe_pkg::ST_RN_MA;
      end
      ppe_pkg::ST_RN_MA: begin
        mul_a          = diff8(rec_q.col_a[7:0], rec_q.col_b[7:0]);
        mul_b          = lr_b;
        col_d[15:8]    = prod_sh[7:0] + rec_q.col_b[15:8];
        state_d        = ppe_pkg::ST_RN_AL;
      end
      ppe_pkg::ST_RN_AL: begin
        mul_a   = $signed({25'b0, mix_a});
        mul_b   = lr_b;
        state_d = ppe_pkg::ST_RN_AF;
      end
      ppe_pkg::ST_RN_AF: begin
        col_d[7:0] = prod[23:16];
        state_d    = ppe_pkg::ST_RN_OUT;
      end
      ppe_pkg::ST_RN_OUT: begin
        if (out_free) begin
          out_vld_d            = 1'b1;
          out_item_d.last_slot = last;
          if (live_q[cnt_q]) begin
            out_item_d.draw_x     = rec_q.pos_x;
            out_item_d.draw_y     = rec_q.pos_y;
            out_item_d.draw_size  = sz_q;
            out_item_d.draw_angle = rec_q.angle;
            out_item_d.draw_color = col_q;
            out_item_d.slot_live  = 1'b1;
          end else begin
            out_item_d.draw_x     = '0;
            out_item_d.draw_y     = '0;
            out_item_d.draw_size  = '0;
            out_item_d.draw_angle = '0;
            out_item_d.draw_color = '0;
            out_item_d.slot_live  = 1'b0;
          end
          cnt_d   = cnt_q + 1'b1;
          state_d = last ? ppe_pkg::ST_IDLE : ppe_pkg::ST_RN_RD;
        end
      end

      default: state_d = ppe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ppe_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
      ring_q    <= IDX_W'(POOL_SIZE - 1);
      rng_q     <= ppe_pkg::RNG_SEED;
      live_q    <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      cnt_q     <= cnt_d;
      ring_q    <= ring_d;
      rng_q     <= rng_d;
      live_q    <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q       <= in_d;
    rec_q      <= rec_d;
    out_item_q <= out_item_d;
    velx_q     <= velx_d;
    vely_q     <= vely_d;
    angle_q    <= angle_d;
    spin_q     <= spin_d;
    lr_q       <= lr_d;
    sz_q       <= sz_d;
    col_q      <= col_d;
  end

endmodule

@@ hdl/ppe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/ppe_mul.sv @@
// Shared signed multiplier, 33 x 18 bits, product registered.
// No dependencies.
module ppe_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [17:0] b_i,
  output logic signed [50:0] prod_o
);

  logic signed [50:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

@@ hdl/ppe_div.sv @@
// Restoring divider for the life ratio: (num << 16) / den, num < den.
// One quotient bit per cycle. No dependencies.
module ppe_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] num_i,
  input  logic [23:0] den_i,
  output logic        done_o,
  output logic [15:0] quo_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [23:0] rem_q, rem_d;
  logic [23:0] den_q, den_d;
  logic [15:0] quo_q, quo_d;
  logic [24:0] rem2;
  logic [24:0] diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    rem2   = {rem_q, 1'b0};
    diff   = rem2 - {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd16;
      rem_d  = num_i;
      den_d  = den_i;
      quo_d  = '0;
    end else if (busy_q) begin
      if (rem2 >= {1'b0, den_q}) begin
        rem_d = diff[23:0];
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = rem2[23:0];
        quo_d = {quo_q[14:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for particle_pool_engine_top: emit, tick and render items
// are checked against an in-bench predictor, with config writes over the APB port.
// Depends on ppe_pkg, ppe_in_if, ppe_out_if and particle_pool_engine_top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          POOL        = 64;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam int          SETTLE      = 400;
  localparam int          HOLD_CYCLES = 500;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         psel, penable, pwrite, pready;
  logic [ppe_pkg::PADDR_W-1:0]  paddr;
  logic [31:0]                  pwdata, prdata;

  ppe_in_if  in_if ();
  ppe_out_if out_if ();

  particle_pool_engine_top #(.POOL_SIZE(POOL)) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Pool predictor state
  logic        p_live [POOL];
  longint      p_px [POOL], p_py [POOL], p_vx [POOL], p_vy [POOL], p_left [POOL];
  logic [15:0] p_ang [POOL], p_sa [POOL], p_sb [POOL];
  logic [31:0] p_ca [POOL], p_cb [POOL];
  logic [23:0] p_tot [POOL];
  int          ring_idx;
  logic [31:0] lfsr;

  logic [30:0] c_jit_x, c_jit_y;
  logic [31:0] c_col0, c_col1;
  logic [15:0] c_size0, c_size1, c_size_jit;
  logic [23:0] c_life;

  ppe_pkg::out_item_t draw_q [$];
  int        n_err = 0;
  bit        quiet = 1'b0;
  int        hold_req = 0, hold_ack = 0, hold_left = 0, stall_left = 0;

  function automatic logic [15:0] next_rand();
    lfsr = lfsr ^ (lfsr << 13);
    lfsr = lfsr ^ (lfsr >> 17);
    lfsr = lfsr ^ (lfsr << 5);
    return lfsr[31:16];
  endfunction

  function automatic longint jitter_of(longint span);
    longint r;
    r = longint'(next_rand()) - 32768;
    return (span * r) >>> 16;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint blend(longint a, longint b, longint l);
    return (a * l + b * (65536 - l)) >> 16;
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < POOL; i++) p_live[i] = 1'b0;
    ring_idx   = POOL - 1;
    lfsr       = ppe_pkg::RNG_SEED;
    c_jit_x    = '0;
    c_jit_y    = '0;
    c_col0     = 32'hFFFFFFFF;
    c_col1     = '0;
    c_size0    = 16'd256;
    c_size1    = '0;
    c_size_jit = '0;
    c_life     = 24'd65536;
  endfunction

  function automatic void model_item(ppe_pkg::in_item_t it);
    longint    ts, sz, spin, l;
    ppe_pkg::out_item_t o;
    logic [31:0] col;
    logic [31:0] c;
    int        s;
    ts = longint'(it.step_time);
    if (it.kind == ppe_pkg::KIND_EMIT) begin
      s = ring_idx;
      p_live[s] = 1'b1;
      p_px[s]   = longint'(it.spawn_x);
      p_py[s]   = longint'(it.spawn_y);
      p_ang[s]  = next_rand();
      p_vx[s]   = clamp32(longint'(it.speed_x) + jitter_of(longint'(c_jit_x)));
      p_vy[s]   = clamp32(longint'(it.speed_y) + jitter_of(longint'(c_jit_y)));
      p_ca[s]   = c_col0;
      p_cb[s]   = c_col1;
      sz = longint'(c_size0) + jitter_of(longint'(c_size_jit));
      if (sz < 0) sz = 0;
      if (sz > 65535) sz = 65535;
      p_sa[s]   = sz[15:0];
      p_sb[s]   = c_size1;
      p_tot[s]  = c_life;
      p_left[s] = longint'(c_life);
      ring_idx  = (s == 0) ? POOL - 1 : s - 1;
    end else if (it.kind == ppe_pkg::KIND_TICK) begin
      spin = (ts * 6835653 + 64'sh80000000) >> 32;
      for (int i = 0; i < POOL; i++) begin
        if (!p_live[i]) continue;
        if (p_left[i] <= 0) begin
          p_live[i] = 1'b0;
          continue;
        end
        p_left[i] -= ts;
        p_px[i]   = clamp32(p_px[i] + ((p_vx[i] * ts) >>> 16));
        p_py[i]   = clamp32(p_py[i] + ((p_vy[i] * ts) >>> 16));
        p_ang[i]  = p_ang[i] + spin[15:0];
      end
    end else if (it.kind == ppe_pkg::KIND_DRAW) begin
      for (int i = 0; i < POOL; i++) begin
        o = '0;
        o.last_slot = (i == POOL - 1);
        if (p_live[i]) begin
          l = 0;
          if (p_left[i] > 0 && p_tot[i] != 0) begin
            l = (p_left[i] << 16) / longint'(p_tot[i]);
            if (l > 65536) l = 65536;
          end
          col = '0;
          for (int b = 0; b < 4; b++) begin
            c = 32'(blend(longint'(p_ca[i][8*b +: 8]), longint'(p_cb[i][8*b +: 8]), l));
            // fade alpha by remaining life
            if (b == 0) c = 32'((longint'(c) * l) >> 16);
            col[8*b +: 8] = c[7:0];
          end
          o.draw_x     = p_px[i][31:0];
          o.draw_y     = p_py[i][31:0];
          o.draw_size  = 16'(blend(longint'(p_sa[i]), longint'(p_sb[i]), l));
          o.draw_angle = p_ang[i];
          o.draw_color = col;
          o.slot_live  = 1'b1;
        end
        draw_q.push_back(o);
      end
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    ppe_pkg::out_item_t exp_d;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (draw_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected draw transfer: %p", out_if.item);
      end else begin
        exp_d = draw_q.pop_front();
        if (out_if.item.draw_x !== exp_d.draw_x || out_if.item.draw_y !== exp_d.draw_y ||
            out_if.item.draw_size !== exp_d.draw_size ||
            out_if.item.draw_angle !== exp_d.draw_angle ||
            out_if.item.draw_color !== exp_d.draw_color ||
            out_if.item.slot_live !== exp_d.slot_live ||
            out_if.item.last_slot !== exp_d.last_slot) begin
          n_err++;
          if (n_err <= 10) begin
            $display("draw mismatch exp x=%h y=%h sz=%h ang=%h col=%h live=%b last=%b",
                     exp_d.draw_x, exp_d.draw_y, exp_d.draw_size, exp_d.draw_angle,
                     exp_d.draw_color, exp_d.slot_live, exp_d.last_slot);
            $display("               got x=%h y=%h sz=%h ang=%h col=%h live=%b last=%b",
                     out_if.item.draw_x, out_if.item.draw_y, out_if.item.draw_size,
                     out_if.item.draw_angle, out_if.item.draw_color,
                     out_if.item.slot_live, out_if.item.last_slot);
          end
        end
      end
    end
  end

  // Receiver: random stall bursts except when quiet, and a long hold on request
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready = 1'b0;
    end else if (quiet) begin
      out_if.ready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready = 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left   = $urandom_range(1, 10) - 1;
      out_if.ready = 1'b0;
    end else begin
      out_if.ready = 1'b1;
    end
  end

  task automatic send_item(ppe_pkg::in_item_t it);
    int g;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      g = $urandom_range(1, 10);
      @(negedge clk_i);
      in_if.valid = 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid = 1'b1;
    in_if.item  = it;
    do @(posedge clk_i); while (!in_if.ready);
    model_item(it);
  endtask

  task automatic apb_write(ppe_pkg::cfg_reg_e r, logic [31:0] v);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {r, 2'b00};
    pwdata  = v;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (r)
      ppe_pkg::REG_VEL_JIT_X:  c_jit_x    = v[30:0];
      ppe_pkg::REG_VEL_JIT_Y:  c_jit_y    = v[30:0];
      ppe_pkg::REG_START_COL:  c_col0     = v;
      ppe_pkg::REG_FINAL_COL:  c_col1     = v;
      ppe_pkg::REG_START_SIZE: c_size0    = v[15:0];
      ppe_pkg::REG_FINAL_SIZE: c_size1    = v[15:0];
      ppe_pkg::REG_SIZE_JIT:   c_size_jit = v[15:0];
      ppe_pkg::REG_LIFESPAN:   c_life     = v[23:0];
      default: ;
    endcase
  endtask

  // Drop valid, drain results, then let a tick or emit finish
  task automatic drain();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (draw_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic ppe_pkg::in_item_t mk_item(logic [1:0] k, logic [31:0] x,
                                                logic [31:0] y, logic [31:0] vx,
                                                logic [31:0] vy, logic [15:0] ts);
    ppe_pkg::in_item_t it;
    it.kind      = k;
    it.spawn_x   = x;
    it.spawn_y   = y;
    it.speed_x   = vx;
    it.speed_y   = vy;
    it.step_time = ts;
    return it;
  endfunction

  function automatic ppe_pkg::in_item_t rand_item();
    int          k;
    logic [1:0]  kd;
    logic [15:0] ts;
    k  = $urandom_range(0, 99);
    kd = (k < 50) ? ppe_pkg::KIND_EMIT : (k < 78) ? ppe_pkg::KIND_TICK :
         (k < 95) ? ppe_pkg::KIND_DRAW : KIND_UNUSED;
    ts = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 4096)) : 16'($urandom);
    return mk_item(kd, $urandom, $urandom, $urandom, $urandom, ts);
  endfunction

  task automatic test_directed();
    send_item(mk_item(ppe_pkg::KIND_EMIT, 32'h7FFFFFFF, 32'h80000000, 32'h00010000,
                      32'hFFFF0000, 16'd0));
    send_item(mk_item(ppe_pkg::KIND_EMIT, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                      32'h80000000, 16'd0));
    send_item(mk_item(ppe_pkg::KIND_DRAW, 0, 0, 0, 0, 16'd0));
    send_item(mk_item(ppe_pkg::KIND_TICK, 0, 0, 0, 0, 16'd0));
    send_item(mk_item(ppe_pkg::KIND_TICK, 0, 0, 0, 0, 16'hFFFF));
    send_item(mk_item(ppe_pkg::KIND_DRAW, 0, 0, 0, 0, 16'd0));
    send_item(mk_item(KIND_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                      16'hFFFF));
    send_item(mk_item(ppe_pkg::KIND_TICK, 0, 0, 0, 0, 16'd1));
    send_item(mk_item(ppe_pkg::KIND_DRAW, 0, 0, 0, 0, 16'd0));
    drain();
    // saturate velocity and size with full-scale jitter
    apb_write(ppe_pkg::REG_VEL_JIT_X, 32'hFFFFFFFF);
    apb_write(ppe_pkg::REG_VEL_JIT_Y, 32'h7FFFFFFF);
    apb_write(ppe_pkg::REG_SIZE_JIT, 32'h0000FFFF);
    apb_write(ppe_pkg::REG_START_SIZE, 32'h0000FFFF);
    repeat (3) send_item(mk_item(ppe_pkg::KIND_EMIT, 0, 0, 32'h7FFFFFFF, 32'h80000000,
                                 16'd0));
    repeat (3) send_item(mk_item(ppe_pkg::KIND_EMIT, 0, 0, 32'h80000000, 32'h7FFFFFFF,
                                 16'd0));
    send_item(mk_item(ppe_pkg::KIND_TICK, 0, 0, 0, 0, 16'hFFFF));
    send_item(mk_item(ppe_pkg::KIND_DRAW, 0, 0, 0, 0, 16'd0));
    drain();
    // zero lifespan: expire on first tick, render with no life left
    apb_write(ppe_pkg::REG_LIFESPAN, 32'h0);
    send_item(mk_item(ppe_pkg::KIND_EMIT, 32'h12345678, 32'h9ABCDEF0, 32'h1000, 32'h2000,
                      16'd0));
    send_item(mk_item(ppe_pkg::KIND_DRAW, 0, 0, 0, 0, 16'd0));
    send_item(mk_item(ppe_pkg::KIND_TICK, 0, 0, 0, 0, 16'd100));
    send_item(mk_item(ppe_pkg::KIND_DRAW, 0, 0, 0, 0, 16'd0));
    drain();
  endtask

  task automatic write_all(bit extreme, bit all_max);
    for (int i = 0; i < 8; i++) begin
      if (!extreme) apb_write(ppe_pkg::cfg_reg_e'(i), $urandom);
      else if (all_max) apb_write(ppe_pkg::cfg_reg_e'(i), 32'hFFFFFFFF);
      else apb_write(ppe_pkg::cfg_reg_e'(i), (i == ppe_pkg::REG_LIFESPAN) ? 32'd1 : 32'd0);
    end
  endtask

  task automatic test_config_sweep();
    for (int p = 0; p < 4; p++) begin
      write_all(p < 2, p == 0);
      repeat (4) send_item(rand_item());
      send_item(mk_item(ppe_pkg::KIND_TICK, 0, 0, 0, 0, 16'($urandom)));
      send_item(mk_item(ppe_pkg::KIND_DRAW, 0, 0, 0, 0, 16'd0));
      drain();
    end
  endtask

  task automatic test_backpressure();
    hold_req++;
    repeat (2) send_item(mk_item(ppe_pkg::KIND_EMIT, $urandom, $urandom, $urandom, $urandom,
                                 16'd0));
    repeat (4) send_item(mk_item(ppe_pkg::KIND_DRAW, 0, 0, 0, 0, 16'd0));
    drain();
  endtask

  task automatic test_random();
    for (int n = 0; n < 230; n++) begin
      if (n > 0 && n % 60 == 0) begin
        drain();
        write_all(1'b0, 1'b0);
        // keep particles alive long enough to age visibly
        apb_write(ppe_pkg::REG_LIFESPAN, $urandom_range(4096, 24'hFFFFFF));
      end
      if (n == 190) quiet = 1'b1;
      send_item(rand_item());
    end
    drain();
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.item   = '0;
    out_if.ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    reset_model();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    if (n_err == 0 && draw_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(30_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/ppe_pkg.sv
hdl/ppe_in_if.sv
hdl/ppe_out_if.sv
hdl/ppe_ram.sv
hdl/ppe_mul.sv
hdl/ppe_div.sv
hdl/particle_pool_engine_top.sv
tb/tb_top.sv
